// ===== design/bidirectional_flow_table_unit_macros.svh =====
// Assertion helpers for the flow table unit.
`ifndef BIDIRECTIONAL_FLOW_TABLE_UNIT_MACROS_SVH
`define BIDIRECTIONAL_FLOW_TABLE_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define BFT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define BFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bft_pkg.sv =====
`timescale 1ns / 1ps
package bft_pkg;
  localparam int unsigned DefTableEntries = 64;
  localparam int unsigned DefIdBits = 16;
  localparam int unsigned OutIdBits = 16;
  localparam int unsigned CountBits = 7;
  localparam int unsigned AddrBits = 64;
  localparam int unsigned PortBits = 16;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_SPARE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_WRITE = 2'd2,
    ST_OUT   = 2'd3
  } state_e;

  // direction-independent key
  typedef struct packed {
    logic                v6;
    logic [AddrBits-1:0] a1_hi;
    logic [AddrBits-1:0] a1_lo;
    logic [AddrBits-1:0] a2_hi;
    logic [AddrBits-1:0] a2_lo;
    logic [PortBits-1:0] p1;
    logic [PortBits-1:0] p2;
  } key_t;

  // command from the sequencer to the cell row
  typedef struct packed {
    logic load;   // latch a new key into cell inputs
    logic write;  // commit add / remove in the selected cell
  } cell_ctl_t;
endpackage

// ===== design/bft_if.sv =====
`timescale 1ns / 1ps
interface bft_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic        is_v6;
  logic [63:0] src_addr_hi;
  logic [63:0] src_addr_lo;
  logic [63:0] dst_addr_hi;
  logic [63:0] dst_addr_lo;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [15:0] conn_id;
  modport source (output valid, func, is_v6, src_addr_hi, src_addr_lo, dst_addr_hi,
                  dst_addr_lo, src_port, dst_port, conn_id, input ready);
  modport sink (input valid, func, is_v6, src_addr_hi, src_addr_lo, dst_addr_hi,
                dst_addr_lo, src_port, dst_port, conn_id, output ready);
endinterface

interface bft_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [15:0] found_id;
  logic        table_full;
  logic [6:0]  entry_count;
  modport source (output valid, hit, found_id, table_full, entry_count, input ready);
  modport sink (input valid, hit, found_id, table_full, entry_count, output ready);
endinterface

// ===== design/bidirectional_flow_table_unit.sv =====
`timescale 1ns / 1ps
// Response word becomes valid after the key register, the registered row match
//   and the commit into the output register.
// The sequencer holds one operation and takes no new request until the
//   response is taken; each response stall delays the next operation.
// Reset (rst_ni low, async): all cells invalid, count zero, no response.
// Stored keys and ids are not cleared; they are only read while valid.
module bidirectional_flow_table_unit
  import bft_pkg::*;
#(
  parameter int unsigned TableEntries = DefTableEntries,
  parameter int unsigned IdBits       = DefIdBits
) (
  input logic   clk_i,
  input logic   rst_ni,
  bft_req_if.sink   req,
  bft_rsp_if.source rsp
);
`include "bidirectional_flow_table_unit_macros.svh"
  localparam int unsigned CntBits = $clog2(TableEntries + 1);

  state_e state_q, state_d;
  key_t   key_q;
  op_e    op_q;
  logic [IdBits-1:0]  id_q;
  logic [CntBits-1:0] count_q, count_d;

  // per-cell wires
  logic [TableEntries:0]   hit_chain, free_chain;
  logic [TableEntries-1:0] match, first_free;
  logic [IdBits-1:0]       cell_id [TableEntries];
  logic [TableEntries-1:0] match_q, free_sel_q;
  logic                    hit_q, any_free_q;
  logic [IdBits-1:0]       found_q;
  logic                    commit;
  cell_ctl_t               ctl;

  logic [63:0] sh, sl, dh, dl;
  logic        src_first;
  key_t        key_d;

  // canonical key: lower endpoint first
  always_comb begin
    sh = req.is_v6 ? req.src_addr_hi : '0;
    dh = req.is_v6 ? req.dst_addr_hi : '0;
    sl = req.is_v6 ? req.src_addr_lo : {32'd0, req.src_addr_lo[31:0]};
    dl = req.is_v6 ? req.dst_addr_lo : {32'd0, req.dst_addr_lo[31:0]};
    if (sh != dh)      src_first = sh < dh;
    else if (sl != dl) src_first = sl < dl;
    else               src_first = req.src_port < req.dst_port;
    key_d.v6 = req.is_v6;
    if (src_first) begin
      key_d.a1_hi = sh; key_d.a1_lo = sl; key_d.p1 = req.src_port;
      key_d.a2_hi = dh; key_d.a2_lo = dl; key_d.p2 = req.dst_port;
    end else begin
      key_d.a1_hi = dh; key_d.a1_lo = dl; key_d.p1 = req.dst_port;
      key_d.a2_hi = sh; key_d.a2_lo = sl; key_d.p2 = req.src_port;
    end
  end

  assign req.ready = (state_q == ST_IDLE);
  assign ctl.load  = req.valid && req.ready;
  assign ctl.write = (state_q == ST_WRITE);

  always_ff @(posedge clk_i) begin
    if (ctl.load) begin
      key_q <= key_d;
      op_q  <= op_e'(req.func);
      id_q  <= IdBits'(req.conn_id);
    end
  end

  // row of cells, priority chains run from entry 0 upward
  assign hit_chain[0]  = 1'b0;
  assign free_chain[0] = 1'b0;
  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    bft_cell #(.IdBits(IdBits)) u_cell (
      .clk_i,
      .rst_ni,
      .key_i       (key_q),
      .id_i        (id_q),
      .wr_add_i    (commit && op_q == OP_ADD && !hit_q && free_sel_q[g]),
      .wr_id_i     (commit && op_q == OP_ADD && match_q[g]),
      .wr_del_i    (commit && op_q == OP_REMOVE && match_q[g]),
      .hit_in_i    (hit_chain[g]),
      .free_in_i   (free_chain[g]),
      .hit_out_o   (hit_chain[g+1]),
      .free_out_o  (free_chain[g+1]),
      .match_o     (match[g]),
      .first_free_o(first_free[g]),
      .id_o        (cell_id[g])
    );
  end
  assign commit = ctl.write;

  // found id: one-hot OR over the row
  logic [IdBits-1:0] found_d;
  always_comb begin
    found_d = '0;
    for (int i = 0; i < TableEntries; i++) begin
      if (match[i]) found_d = found_d | cell_id[i];
    end
  end

  // scan result registered
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN) begin
      match_q    <= match;
      free_sel_q <= first_free;
      hit_q      <= hit_chain[TableEntries];
      any_free_q <= free_chain[TableEntries];
      found_q    <= found_d;
    end
  end

  logic                 full_d;
  logic                 rsp_hit_q, rsp_full_q;
  logic [OutIdBits-1:0] rsp_id_q;

  assign full_d = (op_q == OP_ADD) && !hit_q && !any_free_q;

  always_comb begin
    count_d = count_q;
    if (commit) begin
      if (op_q == OP_ADD && !hit_q && any_free_q) count_d = count_q + 1'b1;
      else if (op_q == OP_REMOVE && hit_q)        count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (ctl.load) state_d = ST_SCAN;
      ST_SCAN:  state_d = ST_WRITE;
      ST_WRITE: state_d = ST_OUT;
      ST_OUT:   if (rsp.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_hit_q  <= hit_q;
      rsp_full_q <= full_d;
      rsp_id_q   <= hit_q ? OutIdBits'(found_q) : '0;
    end
  end

  assign rsp.valid       = (state_q == ST_OUT);
  assign rsp.hit         = rsp_hit_q;
  assign rsp.found_id    = rsp_id_q;
  assign rsp.table_full  = rsp_full_q;
  assign rsp.entry_count = CountBits'(count_q);

  `BFT_ASSERT_IMPL(a_onehot_match, clk_i, rst_ni, state_q == ST_SCAN, $onehot0(match),
                   "more than one cell matched")
  `BFT_ASSERT_NEXT(a_load_scan, clk_i, rst_ni, ctl.load, state_q == ST_SCAN,
                   "accepted word did not start a scan")
  `BFT_ASSERT_IMPL(a_count_range, clk_i, rst_ni, 1'b1, count_q <= CntBits'(TableEntries),
                   "entry count above table size")
  `BFT_ASSERT_NEXT(a_full_nochg, clk_i, rst_ni, commit && full_d, count_q == $past(count_q),
                   "refused add changed the count")
endmodule

// ===== design/bft_cell.sv =====
`timescale 1ns / 1ps
// One table entry. Compares its stored key against the broadcast key and
// forms its part of the first-match / first-free priority chains.
module bft_cell
  import bft_pkg::*;
#(
  parameter int unsigned IdBits = DefIdBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  key_t              key_i,
  input  logic [IdBits-1:0] id_i,
  input  logic              wr_add_i,   // add new key here
  input  logic              wr_id_i,    // overwrite id here
  input  logic              wr_del_i,   // invalidate here
  input  logic              hit_in_i,   // earlier cell already matched
  input  logic              free_in_i,  // earlier cell already free
  output logic              hit_out_o,
  output logic              free_out_o,
  output logic              match_o,
  output logic              first_free_o,
  output logic [IdBits-1:0] id_o
);
  logic              valid_q;
  key_t              key_q;
  logic [IdBits-1:0] id_q;
  logic              eq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_add_i) begin
      valid_q <= 1'b1;
    end else if (wr_del_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_add_i) key_q <= key_i;
    if (wr_add_i || wr_id_i) id_q <= id_i;
  end

  assign eq           = valid_q && (key_q == key_i);
  assign match_o      = eq && !hit_in_i;
  assign first_free_o = !valid_q && !free_in_i;
  assign hit_out_o    = hit_in_i || eq;
  assign free_out_o   = free_in_i || !valid_q;
  assign id_o         = id_q;
endmodule
